@@ sv/assert_macros.svh @@
// Assertion helpers shared by the queue and back-end modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

@@ sv/rfe_pkg.sv @@
`default_nettype none
package rfe_pkg;

    localparam logic [1:0] ACT_REQUEST = 2'd0;
    localparam logic [1:0] ACT_RX_BYTE = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;

    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD       = 2'd1;
    localparam logic [1:0] ST_TIMEOUT   = 2'd2;
    localparam logic [1:0] ST_EXCEPTION = 2'd3;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  FUNC_MASK   = 8'h7F;
    localparam logic [7:0]  FC_WRITE_COIL = 8'h05;
    localparam logic [15:0] COIL_ON     = 16'hFF00;
    localparam logic [15:0] TICK_MAX    = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam int MIN_REPLY     = 5;
    localparam int PAYLOAD_LAG   = 5;
    localparam int QUEUE_DEPTH   = 4;

    typedef struct packed {
        logic            is_req;
        logic [5:0][7:0] frame;
        logic            pay_valid;
        logic [7:0]      pay_byte;
        logic            stat_valid;
        logic [1:0]      status;
        logic [7:0]      exc;
    } t_cmd;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ sv/rfe_front.sv @@
`default_nettype none
module rfe_front #(
    parameter int MAX_FRAME = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_slave_address,
    input  wire logic [7:0]  i_function_code,
    input  wire logic [15:0] i_start_address,
    input  wire logic [15:0] i_quantity_or_value,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_rx_end,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_cmd_valid,
    output rfe_pkg::t_cmd    o_cmd
);
    import rfe_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [15:0]   r_timeout;
    logic          r_awaiting, n_awaiting;
    logic [7:0]    r_slave, n_slave;
    logic [7:0]    r_func, n_func;
    logic [15:0]   r_rx_crc, n_rx_crc;
    logic [CW-1:0] r_rx_count, n_rx_count;
    logic [7:0]    r_delay0, n_delay0;
    logic [7:0]    r_delay1, n_delay1;
    logic          r_header_ok, n_header_ok;
    logic [7:0]    r_reply_exc, n_reply_exc;
    logic          r_exc_seen, n_exc_seen;
    logic [15:0]   r_wait, n_wait;
    logic [15:0]   qv;
    logic          in_range;

    always_comb begin
        n_awaiting  = r_awaiting;
        n_slave     = r_slave;
        n_func      = r_func;
        n_rx_crc    = r_rx_crc;
        n_rx_count  = r_rx_count;
        n_delay0    = r_delay0;
        n_delay1    = r_delay1;
        n_header_ok = r_header_ok;
        n_reply_exc = r_reply_exc;
        n_exc_seen  = r_exc_seen;
        n_wait      = r_wait;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;
        qv          = i_quantity_or_value;
        in_range    = r_rx_count < CW'(MAX_FRAME);
        if (i_function_code == FC_WRITE_COIL) begin
            qv = (i_quantity_or_value != 16'd0) ? COIL_ON : 16'd0;
        end
        if (i_accept) begin
            unique case (i_action)
                ACT_REQUEST: begin
                    o_cmd_valid  = 1'b1;
                    o_cmd.is_req = 1'b1;
                    o_cmd.frame  = {qv[7:0], qv[15:8], i_start_address[7:0],
                                    i_start_address[15:8], i_function_code,
                                    i_slave_address};
                    n_slave      = i_slave_address;
                    n_func       = i_function_code;
                    n_rx_crc     = CRC_INIT;
                    n_rx_count   = '0;
                    n_delay0     = 8'd0;
                    n_delay1     = 8'd0;
                    n_header_ok  = 1'b1;
                    n_reply_exc  = 8'd0;
                    n_exc_seen   = 1'b0;
                    n_wait       = 16'd0;
                    n_awaiting   = 1'b1;
                end
                ACT_RX_BYTE: begin
                    if (r_awaiting) begin
                        n_rx_crc = crc16_byte(r_rx_crc, i_rx_byte);
                        if (!in_range) begin
                            n_header_ok = 1'b0;
                        end else begin
                            if (r_rx_count == CW'(0) && i_rx_byte != r_slave) begin
                                n_header_ok = 1'b0;
                            end
                            if (r_rx_count == CW'(1)) begin
                                if ((i_rx_byte & FUNC_MASK) != (r_func & FUNC_MASK)) begin
                                    n_header_ok = 1'b0;
                                end
                                if (i_rx_byte[7]) begin
                                    n_exc_seen = 1'b1;
                                end
                            end
                            if (r_rx_count == CW'(2) && r_exc_seen) begin
                                n_reply_exc = i_rx_byte;
                            end
                            if (r_rx_count >= CW'(PAYLOAD_LAG)) begin
                                o_cmd.pay_valid = 1'b1;
                                o_cmd.pay_byte  = r_delay1;
                            end
                            n_rx_count = r_rx_count + CW'(1);
                        end
                        n_delay1 = r_delay0;
                        n_delay0 = i_rx_byte;
                        if (i_rx_end) begin
                            o_cmd.stat_valid = 1'b1;
                            if (n_rx_count < CW'(MIN_REPLY) || n_rx_crc != 16'd0
                                || !n_header_ok) begin
                                o_cmd.status = ST_BAD;
                            end else if (n_exc_seen) begin
                                o_cmd.status = ST_EXCEPTION;
                                o_cmd.exc    = n_reply_exc;
                            end else begin
                                o_cmd.status = ST_OK;
                            end
                            n_awaiting = 1'b0;
                        end
                        o_cmd_valid = o_cmd.pay_valid || o_cmd.stat_valid;
                    end
                end
                ACT_TICK: begin
                    if (r_awaiting) begin
                        if (r_wait < TICK_MAX) begin
                            n_wait = r_wait + 16'd1;
                        end
                        if (n_wait >= r_timeout) begin
                            o_cmd_valid      = 1'b1;
                            o_cmd.stat_valid = 1'b1;
                            o_cmd.status     = ST_TIMEOUT;
                            n_awaiting       = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_awaiting  <= 1'b0;
            r_slave     <= 8'd0;
            r_func      <= 8'd0;
            r_rx_crc    <= CRC_INIT;
            r_rx_count  <= '0;
            r_delay0    <= 8'd0;
            r_delay1    <= 8'd0;
            r_header_ok <= 1'b1;
            r_reply_exc <= 8'd0;
            r_exc_seen  <= 1'b0;
            r_wait      <= 16'd0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            r_awaiting  <= n_awaiting;
            r_slave     <= n_slave;
            r_func      <= n_func;
            r_rx_crc    <= n_rx_crc;
            r_rx_count  <= n_rx_count;
            r_delay0    <= n_delay0;
            r_delay1    <= n_delay1;
            r_header_ok <= n_header_ok;
            r_reply_exc <= n_reply_exc;
            r_exc_seen  <= n_exc_seen;
            r_wait      <= n_wait;
        end
    end

endmodule
`default_nettype wire

@@ sv/rfe_queue.sv @@
`default_nettype none
`include "assert_macros.svh"
module rfe_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  rfe_pkg::t_cmd      i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output rfe_pkg::t_cmd      o_data
);
    import rfe_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;

    assign o_full  = r_count == NW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    `ASSERT_CLK(a_count_bound, r_count <= NW'(QUEUE_DEPTH), "queue count exceeds depth")
    `ASSERT_NEVER(a_push_full, i_push && o_full, "transaction written into a full queue")
    `ASSERT_NEVER(a_pop_empty, i_pop && !o_valid, "transaction read from an empty queue")

endmodule
`default_nettype wire

@@ sv/rfe_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module rfe_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  rfe_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    output logic             o_valid,
    input  wire logic        i_pop,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_byte,
    output logic [1:0]       o_status,
    output logic [7:0]       o_exc,
    output logic             o_last
);
    import rfe_pkg::*;

    t_cmd        r_cmd;
    logic        r_active;
    logic [2:0]  r_step;
    logic [15:0] r_crc;
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic [1:0]  r_status;
    logic [7:0]  r_exc;
    logic        r_last;

    logic        adv;
    logic        fin;
    logic [1:0]  item_kind;
    logic [7:0]  item_byte;
    logic [1:0]  item_status;
    logic [7:0]  item_exc;
    logic        item_last;
    logic        crc_step;
    logic [7:0]  frame_byte;

    always_comb begin
        unique case (r_step)
            3'd0:    frame_byte = r_cmd.frame[0];
            3'd1:    frame_byte = r_cmd.frame[1];
            3'd2:    frame_byte = r_cmd.frame[2];
            3'd3:    frame_byte = r_cmd.frame[3];
            3'd4:    frame_byte = r_cmd.frame[4];
            3'd5:    frame_byte = r_cmd.frame[5];
            3'd6:    frame_byte = r_crc[7:0];
            default: frame_byte = r_crc[15:8];
        endcase
    end

    always_comb begin
        item_kind   = KIND_STATUS;
        item_byte   = 8'd0;
        item_status = r_cmd.status;
        item_exc    = r_cmd.exc;
        item_last   = 1'b1;
        fin         = 1'b1;
        crc_step    = 1'b0;
        if (r_cmd.is_req) begin
            item_kind   = KIND_TX;
            item_byte   = frame_byte;
            item_status = ST_OK;
            item_exc    = 8'd0;
            item_last   = r_step == 3'd7;
            fin         = item_last;
            crc_step    = r_step < 3'd6;
        end else if (r_step == 3'd0 && r_cmd.pay_valid) begin
            item_kind   = KIND_PAYLOAD;
            item_byte   = r_cmd.pay_byte;
            item_status = ST_OK;
            item_exc    = 8'd0;
            item_last   = 1'b0;
            fin         = !r_cmd.stat_valid;
        end
    end

    assign adv       = r_active && (!r_out_valid || i_pop);
    assign o_cmd_pop = i_cmd_valid && (!r_active || (adv && fin));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= 3'd0;
            r_crc       <= CRC_INIT;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (o_cmd_pop) begin
                r_active <= 1'b1;
                r_step   <= 3'd0;
                r_crc    <= CRC_INIT;
            end else if (adv) begin
                r_step <= r_step + 3'd1;
                if (crc_step) begin
                    r_crc <= crc16_byte(r_crc, frame_byte);
                end
                if (fin) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (adv) begin
            r_kind   <= item_kind;
            r_byte   <= item_byte;
            r_status <= item_status;
            r_exc    <= item_exc;
            r_last   <= item_last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_kind   = r_kind;
    assign o_byte   = r_byte;
    assign o_status = r_status;
    assign o_exc    = r_exc;
    assign o_last   = r_last;

    `ASSERT_CLK(a_rx_steps, (r_active && !r_cmd.is_req) |-> (r_step <= 3'd1),
        "reply transaction runs past its second result")
    `ASSERT_CLK(a_crc_fresh, (r_active && r_cmd.is_req && r_step == 3'd0) |-> (r_crc == CRC_INIT),
        "frame CRC not restarted for a new request")
    `ASSERT_CLK(a_status_last, (r_out_valid && r_kind == KIND_STATUS) |-> r_last,
        "status result without last flag")

endmodule
`default_nettype wire

@@ sv/rtu_master_frame_engine_top.sv @@
// Channel   Handshake                    Contents
// input     push / full                  action, request fields, received byte, end flag
// result    empty / pop                  kind, byte, status, exception code, last
// config    i_cfg_valid / o_cfg_ready    timeout in ticks
//
// Every input transaction is taken on push while the command queue has room.
// A request yields eight transmit results, one per cycle while popped, with a bytewise CRC.
// A received byte or tick yields up to two results, one per cycle while popped.
// Reset is synchronous and active low; the timeout register resets to 1000 ticks.
// The front keeps accepting while results wait, until the four-entry queue fills.
`default_nettype none
module rtu_master_frame_engine_top #(
    parameter int MAX_FRAME = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_slave_address,
    input  wire logic [7:0]  i_function_code,
    input  wire logic [15:0] i_start_address,
    input  wire logic [15:0] i_quantity_or_value,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_rx_end,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_out_kind,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_status,
    output logic [7:0]       o_exception_code,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);
    import rfe_pkg::*;

    logic accept;
    logic cmd_valid;
    t_cmd cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_data;
    logic q_pop;
    logic out_valid;

    assign accept      = push && !q_full;
    assign full        = q_full;
    assign o_cfg_ready = 1'b1;
    assign empty       = !out_valid;

    rfe_front #(
        .MAX_FRAME(MAX_FRAME)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_action           (i_action),
        .i_slave_address    (i_slave_address),
        .i_function_code    (i_function_code),
        .i_start_address    (i_start_address),
        .i_quantity_or_value(i_quantity_or_value),
        .i_rx_byte          (i_rx_byte),
        .i_rx_end           (i_rx_end),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_data         (i_cfg_data),
        .o_cmd_valid        (cmd_valid),
        .o_cmd              (cmd)
    );

    rfe_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_valid),
        .i_data (cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_data)
    );

    rfe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(q_valid),
        .i_cmd      (q_data),
        .o_cmd_pop  (q_pop),
        .o_valid    (out_valid),
        .i_pop      (pop),
        .o_kind     (o_out_kind),
        .o_byte     (o_out_byte),
        .o_status   (o_status),
        .o_exc      (o_exception_code),
        .o_last     (o_last)
    );

endmodule
`default_nettype wire
